[hdl/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg: shared types, codes and helpers of the complex arithmetic unit
// Operation and status codes, in-flight tag, saturation and width helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package cau_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int DEN_W         = 32;  // width of |b|^2
  localparam int MAG_W         = 33;  // width of a numerator magnitude
  localparam int QBITS         = 17;  // quotient bits kept by the divider

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  // Remainder width: holds the scaled numerator and the divisor at the top bit.
  function automatic int cau_rem_w(input int frac);
    return (MAG_W + frac > DEN_W + QBITS - 1) ? MAG_W + frac : DEN_W + QBITS - 1;
  endfunction

  typedef struct packed {
    logic        clamp;
    logic [15:0] val;
  } sat_t;

  // Control that rides along with an item through the divider stages.
  typedef struct packed {
    logic        is_div;
    logic        dz;
    logic        neg_re;
    logic        neg_im;
    logic        ovf_re;
    logic        ovf_im;
    logic [15:0] fast_re;
    logic [15:0] fast_im;
    logic [1:0]  fast_st;
  } tag_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] im;
    logic [15:0] re;
  } res_t;

  function automatic sat_t cau_sat(input logic signed [32:0] v);
    sat_t s;
    if (v > 33'sd32767) begin
      s.clamp = 1'b1;
      s.val   = 16'h7FFF;
    end else if (v < -33'sd32768) begin
      s.clamp = 1'b1;
      s.val   = 16'h8000;
    end else begin
      s.clamp = 1'b0;
      s.val   = v[15:0];
    end
    return s;
  endfunction

endpackage
`default_nettype wire

[hdl/cau_mul.sv]
// ----------------------------------------------------------------------------
// cau_mul: product and sum stages
// Stage one forms the six partial products, stage two the sums and |b|^2.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_mul
  import cau_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_v,
  input  wire logic [1:0]         cmd,
  input  wire logic signed [15:0] a_re,
  input  wire logic signed [15:0] a_im,
  input  wire logic signed [15:0] b_re,
  input  wire logic signed [15:0] b_im,
  output logic                    out_v,
  output logic [1:0]              cmd_o,
  output logic signed [16:0]      sum_re,
  output logic signed [16:0]      sum_im,
  output logic signed [32:0]      mul_re,
  output logic signed [32:0]      mul_im,
  output logic signed [32:0]      num_re,
  output logic signed [32:0]      num_im,
  output logic [DEN_W-1:0]        den
);

  logic               v1_r;
  logic [1:0]         cmd1_r;
  logic signed [15:0] ar_r, ai_r, br_r, bi_r;
  logic signed [31:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, s_rr_r, s_ii_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r <= cmd;
      ar_r   <= a_re;
      ai_r   <= a_im;
      br_r   <= b_re;
      bi_r   <= b_im;
      p_rr_r <= a_re * b_re;
      p_ii_r <= a_im * b_im;
      p_ri_r <= a_re * b_im;
      p_ir_r <= a_im * b_re;
      s_rr_r <= b_re * b_re;
      s_ii_r <= b_im * b_im;
    end
  end

  logic signed [16:0] ext_ar, ext_ai, ext_br, ext_bi;
  logic signed [32:0] e_rr, e_ii, e_ri, e_ir;

  always_comb begin
    ext_ar = {ar_r[15], ar_r};
    ext_ai = {ai_r[15], ai_r};
    ext_br = {br_r[15], br_r};
    ext_bi = {bi_r[15], bi_r};
    e_rr   = {p_rr_r[31], p_rr_r};
    e_ii   = {p_ii_r[31], p_ii_r};
    e_ri   = {p_ri_r[31], p_ri_r};
    e_ir   = {p_ir_r[31], p_ir_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_o  <= cmd1_r;
      sum_re <= (cmd1_r == CMD_SUB) ? ext_ar - ext_br : ext_ar + ext_br;
      sum_im <= (cmd1_r == CMD_SUB) ? ext_ai - ext_bi : ext_ai + ext_bi;
      mul_re <= e_rr - e_ii;
      mul_im <= e_ri + e_ir;
      num_re <= e_rr + e_ii;
      num_im <= e_ir - e_ri;
      den    <= DEN_W'(s_rr_r) + DEN_W'(s_ii_r);
    end
  end

endmodule
`default_nettype wire

[hdl/cau_prep.sv]
// ----------------------------------------------------------------------------
// cau_prep: result and divider setup stage
// Saturates add, subtract and multiply results; scales the numerator magnitudes
// and flags quotients too large for the kept quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_prep
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_v,
  input  wire logic [1:0]         cmd,
  input  wire logic signed [16:0] sum_re,
  input  wire logic signed [16:0] sum_im,
  input  wire logic signed [32:0] mul_re,
  input  wire logic signed [32:0] mul_im,
  input  wire logic signed [32:0] num_re,
  input  wire logic signed [32:0] num_im,
  input  wire logic [DEN_W-1:0]   den,
  output logic                    out_v,
  output tag_t                    tag,
  output logic [DEN_W-1:0]        den_o,
  output logic [cau_rem_w(FRAC_BITS)-1:0] rem_re,
  output logic [cau_rem_w(FRAC_BITS)-1:0] rem_im
);

  localparam int MW = MAG_W + FRAC_BITS;
  localparam int WW = cau_rem_w(FRAC_BITS);
  localparam int WC = WW + 1;

  logic signed [32:0] f_re, f_im;
  sat_t               s_re, s_im;
  logic [MAG_W-1:0]   mag_re, mag_im;
  logic [MW-1:0]      m_re, m_im;
  logic [WC-1:0]      lim;
  tag_t               tag_nxt;

  always_comb begin
    if (cmd == CMD_MUL) begin
      f_re = mul_re >>> FRAC_BITS;
      f_im = mul_im >>> FRAC_BITS;
    end else begin
      f_re = {{16{sum_re[16]}}, sum_re};
      f_im = {{16{sum_im[16]}}, sum_im};
    end
    s_re   = cau_sat(f_re);
    s_im   = cau_sat(f_im);
    mag_re = num_re[32] ? MAG_W'(-num_re) : MAG_W'(num_re);
    mag_im = num_im[32] ? MAG_W'(-num_im) : MAG_W'(num_im);
    m_re   = MW'(mag_re) << FRAC_BITS;
    m_im   = MW'(mag_im) << FRAC_BITS;
    lim    = WC'(den) << QBITS;

    tag_nxt.is_div  = (cmd == CMD_DIV);
    tag_nxt.dz      = (den == '0);
    tag_nxt.neg_re  = num_re[32];
    tag_nxt.neg_im  = num_im[32];
    tag_nxt.ovf_re  = (WC'(m_re) >= lim);
    tag_nxt.ovf_im  = (WC'(m_im) >= lim);
    tag_nxt.fast_re = s_re.val;
    tag_nxt.fast_im = s_im.val;
    tag_nxt.fast_st = (s_re.clamp || s_im.clamp) ? ST_SAT : ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag    <= tag_nxt;
      den_o  <= den;
      rem_re <= WW'(m_re);
      rem_im <= WW'(m_im);
    end
  end

endmodule
`default_nettype wire

[hdl/cau_div.sv]
// ----------------------------------------------------------------------------
// cau_div: pipelined restoring divider
// One quotient bit per stage for the real and imaginary numerators at once.
// ----------------------------------------------------------------------------
`default_nettype none
module cau_div
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_v,
  input  wire tag_t                          tag,
  input  wire logic [DEN_W-1:0]              den,
  input  wire logic [cau_rem_w(FRAC_BITS)-1:0] rem_re,
  input  wire logic [cau_rem_w(FRAC_BITS)-1:0] rem_im,
  output logic                               out_v,
  output tag_t                               tag_o,
  output logic [QBITS-1:0]                   q_re,
  output logic [QBITS-1:0]                   q_im
);

  localparam int WW = cau_rem_w(FRAC_BITS);

  // Stage k registers hold the result of quotient bit QBITS-1-k.
  logic             v_r     [0:QBITS-1];
  tag_t             tag_r   [0:QBITS-1];
  logic [DEN_W-1:0] den_r   [0:QBITS-1];
  logic [WW-1:0]    rre_r   [0:QBITS-1];
  logic [WW-1:0]    rim_r   [0:QBITS-1];
  logic [QBITS-1:0] qre_r   [0:QBITS-1];
  logic [QBITS-1:0] qim_r   [0:QBITS-1];

  // Stage inputs and next values.
  logic             v_s     [0:QBITS-1];
  tag_t             tag_s   [0:QBITS-1];
  logic [DEN_W-1:0] den_s   [0:QBITS-1];
  logic [WW-1:0]    rre_s   [0:QBITS-1];
  logic [WW-1:0]    rim_s   [0:QBITS-1];
  logic [QBITS-1:0] qre_s   [0:QBITS-1];
  logic [QBITS-1:0] qim_s   [0:QBITS-1];
  logic [WW-1:0]    d_sh    [0:QBITS-1];
  logic             ge_re   [0:QBITS-1];
  logic             ge_im   [0:QBITS-1];
  logic [WW-1:0]    rre_nxt [0:QBITS-1];
  logic [WW-1:0]    rim_nxt [0:QBITS-1];
  logic [QBITS-1:0] qre_nxt [0:QBITS-1];
  logic [QBITS-1:0] qim_nxt [0:QBITS-1];

  always_comb begin
    for (int k = 0; k < QBITS; k++) begin
      if (k == 0) begin
        v_s[k]   = in_v;
        tag_s[k] = tag;
        den_s[k] = den;
        rre_s[k] = rem_re;
        rim_s[k] = rem_im;
        qre_s[k] = '0;
        qim_s[k] = '0;
      end else begin
        v_s[k]   = v_r[k-1];
        tag_s[k] = tag_r[k-1];
        den_s[k] = den_r[k-1];
        rre_s[k] = rre_r[k-1];
        rim_s[k] = rim_r[k-1];
        qre_s[k] = qre_r[k-1];
        qim_s[k] = qim_r[k-1];
      end
      d_sh[k]    = WW'(den_s[k]) << (QBITS - 1 - k);
      ge_re[k]   = (rre_s[k] >= d_sh[k]);
      ge_im[k]   = (rim_s[k] >= d_sh[k]);
      rre_nxt[k] = ge_re[k] ? rre_s[k] - d_sh[k] : rre_s[k];
      rim_nxt[k] = ge_im[k] ? rim_s[k] - d_sh[k] : rim_s[k];
      qre_nxt[k] = qre_s[k];
      qim_nxt[k] = qim_s[k];
      qre_nxt[k][QBITS-1-k] = ge_re[k];
      qim_nxt[k][QBITS-1-k] = ge_im[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QBITS; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      for (int k = 0; k < QBITS; k++) begin
        v_r[k] <= v_s[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QBITS; k++) begin
        tag_r[k] <= tag_s[k];
        den_r[k] <= den_s[k];
        rre_r[k] <= rre_nxt[k];
        rim_r[k] <= rim_nxt[k];
        qre_r[k] <= qre_nxt[k];
        qim_r[k] <= qim_nxt[k];
      end
    end
  end

  assign out_v = v_r[QBITS-1];
  assign tag_o = tag_r[QBITS-1];
  assign q_re  = qre_r[QBITS-1];
  assign q_im  = qim_r[QBITS-1];

endmodule
`default_nettype wire

[hdl/complex_arithmetic_unit_top.sv]
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top: pipelined complex add, subtract, multiply, divide
// Q8.8 complex operands in, saturated Q8.8 result and status out.
// ----------------------------------------------------------------------------
//  Channel | Ports   | tdata (low bit up)               | tuser
//  --------+---------+----------------------------------+-----------------
//  input   | in_*    | a_re, a_im, b_re, b_im (64 bits) | cmd (2 bits)
//  result  | out_*   | res_re, res_im (32 bits)         | status (2 bits)
//
//  One transfer can be accepted every clock cycle while the output buffer has
//  room. Every item passes through the same stages (products, sums, setup,
//  one divider stage per quotient bit) and then the output buffer, whatever
//  its operation. Most of the pipeline is the 17-stage restoring divider.
//  Reset is synchronous and active low; it clears only the valid bits and the
//  output buffer count. When the result side stalls, a two-entry output buffer
//  absorbs the item in flight and the whole pipeline then holds; nothing is
//  dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
module complex_arithmetic_unit_top
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // a_re[15:0], a_im[31:16], b_re[47:32], b_im[63:48]
  input  wire logic [1:0]  in_tuser,   // cmd[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // res_re[15:0], res_im[31:16]
  output logic [1:0]       out_tuser   // status[1:0]
);

  localparam int WW = cau_rem_w(FRAC_BITS);

  // The pipeline advances as a whole whenever the output buffer has room.
  logic en;

  logic               m_v;
  logic [1:0]         m_cmd;
  logic signed [16:0] m_sum_re, m_sum_im;
  logic signed [32:0] m_mul_re, m_mul_im, m_num_re, m_num_im;
  logic [DEN_W-1:0]   m_den;

  cau_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (in_tvalid),
    .cmd    (in_tuser),
    .a_re   (in_tdata[15:0]),
    .a_im   (in_tdata[31:16]),
    .b_re   (in_tdata[47:32]),
    .b_im   (in_tdata[63:48]),
    .out_v  (m_v),
    .cmd_o  (m_cmd),
    .sum_re (m_sum_re),
    .sum_im (m_sum_im),
    .mul_re (m_mul_re),
    .mul_im (m_mul_im),
    .num_re (m_num_re),
    .num_im (m_num_im),
    .den    (m_den)
  );

  logic             p_v;
  tag_t             p_tag;
  logic [DEN_W-1:0] p_den;
  logic [WW-1:0]    p_rem_re, p_rem_im;

  cau_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (m_v),
    .cmd    (m_cmd),
    .sum_re (m_sum_re),
    .sum_im (m_sum_im),
    .mul_re (m_mul_re),
    .mul_im (m_mul_im),
    .num_re (m_num_re),
    .num_im (m_num_im),
    .den    (m_den),
    .out_v  (p_v),
    .tag    (p_tag),
    .den_o  (p_den),
    .rem_re (p_rem_re),
    .rem_im (p_rem_im)
  );

  logic             d_v;
  tag_t             d_tag;
  logic [QBITS-1:0] d_q_re, d_q_im;

  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_v   (p_v),
    .tag    (p_tag),
    .den    (p_den),
    .rem_re (p_rem_re),
    .rem_im (p_rem_im),
    .out_v  (d_v),
    .tag_o  (d_tag),
    .q_re   (d_q_re),
    .q_im   (d_q_im)
  );

  // Quotient sign and saturation. A negative quotient may reach magnitude
  // 32768; a positive one stops at 32767.
  logic [QBITS-1:0] lim_re, lim_im;
  logic             clp_re, clp_im;
  logic [15:0]      dv_re, dv_im;
  res_t             res;

  always_comb begin
    lim_re = d_tag.neg_re ? QBITS'(32768) : QBITS'(32767);
    lim_im = d_tag.neg_im ? QBITS'(32768) : QBITS'(32767);
    clp_re = d_tag.ovf_re || (d_q_re > lim_re);
    clp_im = d_tag.ovf_im || (d_q_im > lim_im);
    if (clp_re) begin
      dv_re = d_tag.neg_re ? 16'h8000 : 16'h7FFF;
    end else begin
      dv_re = d_tag.neg_re ? 16'(-d_q_re) : d_q_re[15:0];
    end
    if (clp_im) begin
      dv_im = d_tag.neg_im ? 16'h8000 : 16'h7FFF;
    end else begin
      dv_im = d_tag.neg_im ? 16'(-d_q_im) : d_q_im[15:0];
    end

    if (!d_tag.is_div) begin
      res.re     = d_tag.fast_re;
      res.im     = d_tag.fast_im;
      res.status = d_tag.fast_st;
    end else if (d_tag.dz) begin
      res.re     = '0;
      res.im     = '0;
      res.status = ST_DZ;
    end else begin
      res.re     = dv_re;
      res.im     = dv_im;
      res.status = (clp_re || clp_im) ? ST_SAT : ST_OK;
    end
  end

  // Two-entry output buffer: main entry drives the ports, skid entry catches
  // the item that arrives during the cycle the result side first stalls.
  logic [1:0] cnt_r, cnt_nxt;
  res_t       main_r, main_nxt, skid_r, skid_nxt;
  logic       push, pop;

  assign en         = (cnt_r != 2'd2);
  assign in_tready  = en;
  assign push       = d_v && en;
  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;

  always_comb begin
    cnt_nxt  = cnt_r;
    main_nxt = main_r;
    skid_nxt = skid_r;
    case (cnt_r)
      2'd0: begin
        if (push) begin
          main_nxt = res;
          cnt_nxt  = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          main_nxt = res;
        end else if (push) begin
          skid_nxt = res;
          cnt_nxt  = 2'd2;
        end else if (pop) begin
          cnt_nxt  = 2'd0;
        end
      end
      2'd2: begin
        if (pop) begin
          main_nxt = skid_r;
          cnt_nxt  = 2'd1;
        end
      end
      default: begin
        cnt_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tdata = {main_r.im, main_r.re};
  assign out_tuser = main_r.status;

`ifndef SYNTHESIS
  // A divide-by-zero result always carries zero parts.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_DZ) |-> (out_tdata == 32'd0))
    else $error("divide-by-zero result with nonzero parts");

  // A push into a one-entry buffer while the result side stalls fills it, and input is then refused.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) && !out_tready && push |=> !in_tready)
    else $error("output buffer did not fill on a stall");

  // Input is refused only while a result is on offer.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input refused with no pending result");

  // The status code stays within its three defined values.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != 2'd3))
    else $error("undefined status code");
`endif

endmodule
`default_nettype wire
